[design/skg_pkg.sv]
// ---------------------------------------------------------------------------
// skg_pkg: shared types and constants for the scalar kalman gated unit
// control word layout, datapath operations, branch conditions, step labels
// and the microcode program
// ---------------------------------------------------------------------------
package skg_pkg;

    // field and datapath widths
    localparam int MEAS_W  = 16;
    localparam int CFG_W   = 16;
    localparam int EST_W   = 24;   // signed q8 estimate, spans a 16-bit sample
    localparam int VAR_W   = 22;   // unsigned q8 variance, holds cap plus q
    localparam int DEN_W   = 23;   // predicted variance plus r
    localparam int REM_W   = 24;   // divider partial remainder after shift
    localparam int DIFF_W  = 25;   // signed innovation
    localparam int GAIN_W  = 8;    // gain is always below 256
    localparam int MULB_W  = 26;   // signed multiplier b operand
    localparam int PROD_W  = 35;   // signed product
    localparam int STEP_W  = 4;
    localparam int LOOP_W  = 3;

    // constants of the filter
    localparam logic [CFG_W-1:0] DEFAULT_NOISE_Q8 = 16'd256;
    localparam logic [VAR_W-1:0] DEFAULT_CAP_Q8   = 22'd2560000;
    localparam logic [EST_W:0]   HALF_Q8          = 25'd128;
    localparam logic [LOOP_W-1:0] DIV_LAST_BIT    = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
    localparam logic [1:0] REG_VARIANCE_CAP  = 2'd2;
    localparam logic [1:0] REG_JUMP_LIMIT    = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SKIP = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_MUL_DIFF,
        OP_UPD_EST,
        OP_UPD_VAR,
        OP_PRIME,
        OP_EMIT_OK,
        OP_EMIT_SKIP,
        OP_EMIT_ERR
    } t_op;

    // branch conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_ERROR,
        COND_UNPRIMED,
        COND_GATE,
        COND_LOOP
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic              hold;     // stay on this step while output is busy
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic item_err;
        logic primed;
        logic gate_trip;
        logic loop_more;
        logic out_busy;
    } t_flags;

    // program step labels
    localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIFF     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIVINIT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIVSTEP  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MUL      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_UPD_EST  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_UPD_VAR  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PRIME    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EMIT_OK  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT_SKP = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT_ERR = 4'd11;

    // microcode program
    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] addr);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: STEP_FETCH};
        unique case (addr)
            STEP_FETCH:    w = '{OP_LOAD,      COND_NO_INPUT, 1'b0, STEP_FETCH};
            STEP_CHECK:    w = '{OP_NOP,       COND_ERROR,    1'b0, STEP_EMIT_ERR};
            STEP_DIFF:     w = '{OP_DIFF,      COND_UNPRIMED, 1'b0, STEP_PRIME};
            STEP_DIVINIT:  w = '{OP_DIVINIT,   COND_GATE,     1'b0, STEP_EMIT_SKP};
            STEP_DIVSTEP:  w = '{OP_DIVSTEP,   COND_LOOP,     1'b0, STEP_DIVSTEP};
            STEP_MUL:      w = '{OP_MUL_DIFF,  COND_NEVER,    1'b0, STEP_FETCH};
            STEP_UPD_EST:  w = '{OP_UPD_EST,   COND_NEVER,    1'b0, STEP_FETCH};
            STEP_UPD_VAR:  w = '{OP_UPD_VAR,   COND_ALWAYS,   1'b0, STEP_EMIT_OK};
            STEP_PRIME:    w = '{OP_PRIME,     COND_NEVER,    1'b0, STEP_FETCH};
            STEP_EMIT_OK:  w = '{OP_EMIT_OK,   COND_ALWAYS,   1'b1, STEP_FETCH};
            STEP_EMIT_SKP: w = '{OP_EMIT_SKIP, COND_ALWAYS,   1'b1, STEP_FETCH};
            STEP_EMIT_ERR: w = '{OP_EMIT_ERR,  COND_ALWAYS,   1'b1, STEP_FETCH};
            default:       w = '{OP_NOP,       COND_ALWAYS,   1'b0, STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

[design/skg_sequencer.sv]
// ---------------------------------------------------------------------------
// skg_sequencer: step counter and microcode rom
// fetches one control word per step and resolves conditional jumps
// ---------------------------------------------------------------------------
module skg_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  skg_pkg::t_flags i_flags,
    output skg_pkg::t_ctrl  o_ctrl,
    output logic            o_at_fetch
);

    logic [skg_pkg::STEP_W-1:0] r_pc;
    logic [skg_pkg::STEP_W-1:0] n_pc;
    skg_pkg::t_ctrl             w_ctrl;
    logic                       w_take;

    // control word of the current step
    assign w_ctrl     = skg_pkg::rom_word(r_pc);
    assign o_ctrl     = w_ctrl;
    assign o_at_fetch = (r_pc == skg_pkg::STEP_FETCH);

    // branch condition
    always_comb begin
        w_take = 1'b0;
        unique case (w_ctrl.cond)
            skg_pkg::COND_NEVER:    w_take = 1'b0;
            skg_pkg::COND_ALWAYS:   w_take = 1'b1;
            skg_pkg::COND_NO_INPUT: w_take = !i_flags.in_valid;
            skg_pkg::COND_ERROR:    w_take = i_flags.item_err;
            skg_pkg::COND_UNPRIMED: w_take = !i_flags.primed;
            skg_pkg::COND_GATE:     w_take = i_flags.gate_trip;
            skg_pkg::COND_LOOP:     w_take = i_flags.loop_more;
            default:                w_take = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (w_ctrl.hold && i_flags.out_busy) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_ctrl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= skg_pkg::STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[design/skg_datapath.sv]
// ---------------------------------------------------------------------------
// skg_datapath: filter state, configuration, shared multiplier and divider
// executes the operation named by the control word each cycle
// ---------------------------------------------------------------------------
module skg_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skg_pkg::t_ctrl                    i_ctrl,
    output skg_pkg::t_flags                   o_flags,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [skg_pkg::CFG_W-1:0]         i_cfg_data,
    // input transaction
    input  logic                              i_in_valid,
    input  logic signed [skg_pkg::MEAS_W-1:0] i_measurement,
    input  logic signed [skg_pkg::MEAS_W-1:0] i_aux_value,
    input  logic [1:0]                        i_value_count,
    input  logic                              i_is_candidate,
    // output transaction
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [skg_pkg::MEAS_W-1:0] o_estimate,
    output logic signed [skg_pkg::MEAS_W-1:0] o_aux_out
);

    // configuration registers
    logic [skg_pkg::CFG_W-1:0] r_process_noise;
    logic [skg_pkg::CFG_W-1:0] r_measure_noise;
    logic [skg_pkg::CFG_W-1:0] r_variance_cap;
    logic [7:0]                r_jump_limit;

    // filter state
    logic signed [skg_pkg::EST_W-1:0] r_est;
    logic [skg_pkg::VAR_W-1:0]        r_var;
    logic                             r_primed;

    // latched item
    logic signed [skg_pkg::EST_W-1:0]  r_meas_q8;
    logic signed [skg_pkg::MEAS_W-1:0] r_aux;
    logic                              r_item_err;

    // scratch
    logic signed [skg_pkg::DIFF_W-1:0] r_diff;
    logic [skg_pkg::VAR_W-1:0]         r_pp;
    logic [skg_pkg::DEN_W-1:0]         r_den;
    logic [skg_pkg::REM_W-1:0]         r_rem;
    logic [skg_pkg::GAIN_W-1:0]        r_k;
    logic [skg_pkg::LOOP_W-1:0]        r_loop;
    logic signed [skg_pkg::PROD_W-1:0] r_prod;

    // output register
    logic                              r_out_valid;
    logic [1:0]                        r_status;
    logic signed [skg_pkg::MEAS_W-1:0] r_estimate;
    logic signed [skg_pkg::MEAS_W-1:0] r_aux_out;

    logic [skg_pkg::CFG_W-1:0]         w_q_eff;
    logic [skg_pkg::CFG_W-1:0]         w_r_eff;
    logic [skg_pkg::VAR_W-1:0]         w_cap_eff;
    logic [skg_pkg::DIFF_W-1:0]        w_abs_diff;
    logic [skg_pkg::VAR_W-1:0]         w_ppc;
    logic [skg_pkg::REM_W-1:0]         w_shift;
    logic                              w_qbit;
    logic signed [skg_pkg::GAIN_W:0]   w_mul_a;
    logic signed [skg_pkg::MULB_W-1:0] w_mul_b;
    logic signed [skg_pkg::PROD_W-1:0] w_prod;
    logic signed [skg_pkg::EST_W+2:0]  w_est_sum;
    logic signed [skg_pkg::EST_W:0]    w_round;
    logic                              w_out_busy;

    // effective configuration, zero selects the default
    assign w_q_eff   = (r_process_noise == '0) ? skg_pkg::DEFAULT_NOISE_Q8 : r_process_noise;
    assign w_r_eff   = (r_measure_noise == '0) ? skg_pkg::DEFAULT_NOISE_Q8 : r_measure_noise;
    assign w_cap_eff = (r_variance_cap == '0) ? skg_pkg::DEFAULT_CAP_Q8
                                              : skg_pkg::VAR_W'(r_variance_cap);

    // outlier gate
    assign w_abs_diff = r_diff[skg_pkg::DIFF_W-1] ? skg_pkg::DIFF_W'(-r_diff)
                                                  : skg_pkg::DIFF_W'(r_diff);

    // clamp of the predicted variance
    assign w_ppc = (r_pp > w_cap_eff) ? w_cap_eff : r_pp;

    // restoring divider step
    assign w_shift = {r_rem[skg_pkg::REM_W-2:0], 1'b0};
    assign w_qbit  = (w_shift >= skg_pkg::REM_W'(r_den));

    // shared multiplier: gain times innovation or times predicted variance
    assign w_mul_a = $signed({1'b0, r_k});
    assign w_mul_b = (i_ctrl.op == skg_pkg::OP_UPD_EST)
                   ? $signed({4'b0000, r_pp})
                   : skg_pkg::MULB_W'(r_diff);
    assign w_prod  = w_mul_a * w_mul_b;

    // estimate update and rounding
    assign w_est_sum = (skg_pkg::EST_W+3)'(r_est)
                     + $signed(r_prod[skg_pkg::PROD_W-1:8]);
    assign w_round   = (skg_pkg::EST_W+1)'(r_est) + $signed(skg_pkg::HALF_Q8);

    assign w_out_busy = r_out_valid && i_out_stall;

    assign o_flags = '{
        in_valid:  i_in_valid,
        item_err:  r_item_err,
        primed:    r_primed,
        gate_trip: (r_jump_limit != '0)
                   && (w_abs_diff > skg_pkg::DIFF_W'({r_jump_limit, 8'h00})),
        loop_more: (r_loop != '0),
        out_busy:  w_out_busy
    };

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise <= skg_pkg::DEFAULT_NOISE_Q8;
            r_measure_noise <= skg_pkg::DEFAULT_NOISE_Q8;
            r_variance_cap  <= '0;
            r_jump_limit    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                skg_pkg::REG_PROCESS_NOISE: r_process_noise <= i_cfg_data;
                skg_pkg::REG_MEASURE_NOISE: r_measure_noise <= i_cfg_data;
                skg_pkg::REG_VARIANCE_CAP:  r_variance_cap  <= i_cfg_data;
                skg_pkg::REG_JUMP_LIMIT:    r_jump_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // filter state and primed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_var    <= '0;
            r_primed <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                skg_pkg::OP_PRIME: begin
                    r_est    <= r_meas_q8;
                    r_var    <= skg_pkg::VAR_W'(w_r_eff);
                    r_primed <= 1'b1;
                end
                skg_pkg::OP_UPD_EST: r_est <= w_est_sum[skg_pkg::EST_W-1:0];
                skg_pkg::OP_UPD_VAR: r_var <= r_pp - r_prod[skg_pkg::VAR_W+7:8];
                default: ;
            endcase
        end
    end

    // item latch and arithmetic scratch
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            skg_pkg::OP_LOAD: begin
                if (i_in_valid) begin
                    r_meas_q8  <= {i_measurement, 8'h00};
                    r_aux      <= (i_value_count >= 2'd2) ? i_aux_value : '0;
                    r_item_err <= !i_is_candidate || (i_value_count == 2'd0);
                end
            end
            skg_pkg::OP_DIFF: begin
                r_diff <= skg_pkg::DIFF_W'(r_meas_q8) - skg_pkg::DIFF_W'(r_est);
                r_pp   <= r_var + skg_pkg::VAR_W'(w_q_eff);
            end
            skg_pkg::OP_DIVINIT: begin
                r_pp   <= w_ppc;
                r_den  <= skg_pkg::DEN_W'(w_ppc) + skg_pkg::DEN_W'(w_r_eff);
                r_rem  <= skg_pkg::REM_W'(w_ppc);
                r_k    <= '0;
                r_loop <= skg_pkg::DIV_LAST_BIT;
            end
            skg_pkg::OP_DIVSTEP: begin
                r_rem  <= w_qbit ? (w_shift - skg_pkg::REM_W'(r_den)) : w_shift;
                r_k    <= {r_k[skg_pkg::GAIN_W-2:0], w_qbit};
                r_loop <= r_loop - 1'b1;
            end
            skg_pkg::OP_MUL_DIFF: r_prod <= w_prod;
            skg_pkg::OP_UPD_EST:  r_prod <= w_prod;
            default: ;
        endcase
    end

    // output register, refilled once the previous transaction has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_busy) begin
            unique case (i_ctrl.op)
                skg_pkg::OP_EMIT_OK: begin
                    r_out_valid <= 1'b1;
                    r_status    <= skg_pkg::STATUS_OK;
                    r_estimate  <= w_round[skg_pkg::EST_W-1:8];
                    r_aux_out   <= r_aux;
                end
                skg_pkg::OP_EMIT_SKIP: begin
                    r_out_valid <= 1'b1;
                    r_status    <= skg_pkg::STATUS_SKIP;
                    r_estimate  <= '0;
                    r_aux_out   <= '0;
                end
                skg_pkg::OP_EMIT_ERR: begin
                    r_out_valid <= 1'b1;
                    r_status    <= skg_pkg::STATUS_ERR;
                    r_estimate  <= '0;
                    r_aux_out   <= '0;
                end
                default: r_out_valid <= 1'b0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_estimate  = r_estimate;
    assign o_aux_out   = r_aux_out;

endmodule

[design/scalar_kalman_gated_unit.sv]
// ---------------------------------------------------------------------------
// scalar_kalman_gated_unit: one-dimensional q8 kalman filter with outlier gate
// microcoded sequencer driving a datapath with one multiplier and a
// radix-2 restoring divider
// ---------------------------------------------------------------------------
// One transaction is worked on at a time. A filtered sample passes from
// acceptance to the result register through the bit-serial gain divider
// loop of the microcode program; the first sample after reset (priming),
// a gated sample and an error item take paths that bypass the loop. The
// result register lets the next transaction be accepted while a result is
// still stalled; the program only waits on its emit step when the previous
// result has not yet left. Configuration writes take effect at once and are
// expected only while the unit is idle.
module scalar_kalman_gated_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [skg_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [skg_pkg::MEAS_W-1:0] i_measurement,
    input  logic signed [skg_pkg::MEAS_W-1:0] i_aux_value,
    input  logic [1:0]                        i_value_count,
    input  logic                              i_is_candidate,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [skg_pkg::MEAS_W-1:0] o_estimate,
    output logic signed [skg_pkg::MEAS_W-1:0] o_aux_out
);

    skg_pkg::t_ctrl  w_ctrl;
    skg_pkg::t_flags w_flags;
    logic            w_at_fetch;

    // input is taken only on the fetch step
    assign o_in_stall = !w_at_fetch;

    // control program
    skg_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl),
        .o_at_fetch (w_at_fetch)
    );

    // filter datapath
    skg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_flags        (w_flags),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_measurement  (i_measurement),
        .i_aux_value    (i_aux_value),
        .i_value_count  (i_value_count),
        .i_is_candidate (i_is_candidate),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_estimate     (o_estimate),
        .o_aux_out      (o_aux_out)
    );

endmodule
